### hw/rtl/npg_pkg.sv
// Shared constants for the n-th prime generator.
package npg_pkg;

   // Fixed payload widths of the request and response channels
   localparam int INDEX_WIDTH = 13;
   localparam int VALUE_WIDTH = 16;

   // Defaults for the top-level parameters
   localparam int DEFAULT_TABLE_DEPTH = 4096;
   localparam int DEFAULT_PRIME_WIDTH = 16;

   // The table always starts with the first prime
   localparam int FIRST_PRIME = 2;

endpackage

### hw/rtl/npg_if.sv
// Valid/ready channel interfaces for requests and responses of the prime generator.
interface npg_req_if;
   logic                                valid;
   logic                                ready;
   logic [npg_pkg::INDEX_WIDTH-1:0]     requested_index;

   modport source (output valid, output requested_index, input ready);
   modport sink   (input valid, input requested_index, output ready);
endinterface

interface npg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [npg_pkg::VALUE_WIDTH-1:0]     prime_value;
   logic                                range_error;

   modport source (output valid, output prime_value, output range_error, input ready);
   modport sink   (input valid, input prime_value, input range_error, output ready);
endinterface

### hw/rtl/npg_divider.sv
// Restoring radix-2 divider giving quotient and remainder, one bit per cycle.
module npg_divider #(
   parameter int WIDTH = npg_pkg::DEFAULT_PRIME_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;

   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   // One restoring step: shift in the next dividend bit, try to subtract
   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         // Last bit: drop busy and flag the result
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### hw/rtl/nth_prime_generator_unit.sv
// Top level of the n-th prime generator: prime table memory, search sequencer, response register.
//
// Request channel (req_chan): one item carries requested_index n, 1 meaning the first prime.
// Response channel (rsp_chan): one item per request with prime_value and range_error.
// A request of 0, or above TABLE_DEPTH, answers range_error = 1 with value 0. A request that
// runs the candidate to the largest PRIME_WIDTH-bit value also answers range_error = 1 with
// value 0 once its search stops.
// A request for a prime already in the table answers from the table without a search.
// Otherwise the block extends its table of primes. Each new candidate is divided in the
// serial divider by the stored primes in turn, up to the first prime that divides it or
// whose square exceeds it, and is appended to the table when none divides it.
// One request is worked at a time; the next is taken once the sequencer is idle again,
// even while the previous response still waits in the output register.
// The table lives in one synchronous memory with one write port and one read port. Entry 0
// reads as 2 and only entries below the prime count are ever used, so reset needs no clearing pass.
// Reset empties the response register and restarts the table with the single prime 2.
// When the receiver stalls, the response holds steady and the sequencer waits for it before writing the next one.
module nth_prime_generator_unit #(
   parameter int TABLE_DEPTH = npg_pkg::DEFAULT_TABLE_DEPTH,
   parameter int PRIME_WIDTH = npg_pkg::DEFAULT_PRIME_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   npg_req_if.sink    req_chan,
   npg_rsp_if.source  rsp_chan
);

   localparam int IDX_W  = npg_pkg::INDEX_WIDTH;
   localparam int VAL_W  = npg_pkg::VALUE_WIDTH;
   localparam int CMP_W  = IDX_W + 1;
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int EXT_W  = PRIME_WIDTH + VAL_W;

   localparam logic [PRIME_WIDTH-1:0] FIRST   = PRIME_WIDTH'(npg_pkg::FIRST_PRIME);
   localparam logic [PRIME_WIDTH-1:0] CAND_MAX = '1;

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_TRIAL  = 3'd2;
   localparam logic [2:0] S_LOAD   = 3'd3;
   localparam logic [2:0] S_DIVIDE = 3'd4;
   localparam logic [2:0] S_APPEND = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [IDX_W-1:0]       index_ff, index_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       trial_ff, trial_in;
   logic [PRIME_WIDTH-1:0] cand_ff, cand_in;
   logic [PRIME_WIDTH-1:0] prime_ff, prime_in;
   logic                   error_ff, error_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                   rsp_error_ff, rsp_error_in;

   // Prime table memory
   logic [PRIME_WIDTH-1:0] prime_mem [TABLE_DEPTH];
   logic [PRIME_WIDTH-1:0] mem_q_ff;
   logic                   rd_zero_ff;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   wr_en;
   logic [PRIME_WIDTH-1:0] rd_value;

   logic                   div_start;
   logic                   div_done;
   logic [PRIME_WIDTH-1:0] div_quo;
   logic [PRIME_WIDTH-1:0] div_rem;

   logic [CMP_W-1:0]       n_ext;
   logic [CMP_W-1:0]       count_ext;
   logic                   req_bad;
   logic                   known;
   logic                   out_free;
   logic [IDX_W-1:0]       n_minus_one;
   logic [EXT_W-1:0]       rd_ext;

   assign n_ext       = CMP_W'(index_ff);
   assign count_ext   = CMP_W'(count_ff);
   assign known       = count_ext >= n_ext;
   assign req_bad     = (req_chan.requested_index == '0) ||
                        (CMP_W'(req_chan.requested_index) > CMP_W'(TABLE_DEPTH));
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign n_minus_one = index_ff - IDX_W'(1);

   // Read the trial prime while testing, otherwise hold the answer entry
   assign rd_addr  = (state_ff == S_TRIAL) ? trial_ff[ADDR_W-1:0] : n_minus_one[ADDR_W-1:0];
   assign rd_value = rd_zero_ff ? FIRST : mem_q_ff;
   assign rd_ext   = EXT_W'(rd_value);
   // Appends go to the entry at the count, which is never used before it is written
   assign wr_en    = (state_ff == S_APPEND) && (count_ext < CMP_W'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prime_mem[count_ff[ADDR_W-1:0]] <= cand_ff;
      end
      mem_q_ff   <= prime_mem[rd_addr];
      rd_zero_ff <= (rd_addr == '0);
   end

   assign div_start = (state_ff == S_LOAD);

   npg_divider #(
      .WIDTH (PRIME_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cand_ff),
      .divisor   (rd_value),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Search sequencer
   always_comb begin
      state_in     = state_ff;
      index_in     = index_ff;
      count_in     = count_ff;
      trial_in     = trial_ff;
      cand_in      = cand_ff;
      prime_in     = prime_ff;
      error_in     = error_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;

      // Drop the response once the receiver takes it
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               index_in = req_chan.requested_index;
               error_in = req_bad;
               state_in = req_bad ? S_RESP : S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (known) begin
               state_in = S_RESP;
            end else if (cand_ff == CAND_MAX) begin
               error_in = 1'b1;
               state_in = S_RESP;
            end else begin
               cand_in  = cand_ff + PRIME_WIDTH'(1);
               trial_in = '0;
               state_in = S_TRIAL;
            end
         end
         S_TRIAL: begin
            state_in = (trial_ff >= count_ff) ? S_APPEND : S_LOAD;
         end
         S_LOAD: begin
            prime_in = rd_value;
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_done) begin
               if (div_quo < prime_ff) begin
                  state_in = S_APPEND;
               end else if (div_rem == '0) begin
                  state_in = S_SEARCH;
               end else begin
                  trial_in = trial_ff + CNT_W'(1);
                  state_in = S_TRIAL;
               end
            end
         end
         S_APPEND: begin
            if (wr_en) begin
               count_in = count_ff + CNT_W'(1);
            end
            state_in = S_SEARCH;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_error_in = error_ff;
               rsp_value_in = error_ff ? '0 : rd_ext[VAL_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CNT_W'(1);
         cand_ff      <= FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      index_ff     <= index_in;
      trial_ff     <= trial_in;
      prime_ff     <= prime_in;
      error_ff     <= error_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.prime_value = rsp_value_ff;
   assign rsp_chan.range_error = rsp_error_ff;

endmodule

### hw/rtl/npg_checker.sv
// Port-level assertions for the n-th prime generator and their bind to the top level.
module npg_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [npg_pkg::INDEX_WIDTH-1:0]  req_requested_index,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [npg_pkg::VALUE_WIDTH-1:0]  rsp_prime_value,
   input logic                             rsp_range_error
);

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prime_value)
                                  && $stable(rsp_range_error))
      else $error("stalled response changed");

   // One request at a time: no transfer right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // An error response carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_prime_value == '0)
      else $error("error response with nonzero value");

   // A good response never carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_range_error |-> rsp_prime_value != '0)
      else $error("zero prime returned");

   // A zero request with a free output answers an error through the response state and register
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_requested_index == '0) && !rsp_valid
      |=> ##1 rsp_valid && rsp_range_error)
      else $error("zero request not flagged in time");

endmodule

bind nth_prime_generator_unit npg_checker u_npg_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .req_requested_index (req_chan.requested_index),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_prime_value     (rsp_chan.prime_value),
   .rsp_range_error     (rsp_chan.range_error)
);

### test/nth_prime_generator_unit_test.sv
// Self-checking testbench for the n-th prime generator: directed and random requests, trial-division model.

// One expected response of the block
typedef struct packed {
   logic [npg_pkg::VALUE_WIDTH-1:0] prime_value;
   logic                            range_error;
} prime_answer_type;

// Keeps its own prime table and the responses still owed by the block
class nth_prime_scoreboard_type;
   int unsigned      primes_found [npg_pkg::DEFAULT_TABLE_DEPTH];
   int unsigned      found_count;
   int unsigned      last_tried;
   prime_answer_type owed_answers [$];
   int               fail_count;

   function new();
      primes_found[0] = npg_pkg::FIRST_PRIME;
      found_count     = 1;
      last_tried      = npg_pkg::FIRST_PRIME;
      fail_count      = 0;
   endfunction

   // Trial-divide by stored primes, stop once p*p passes the candidate
   function bit has_divisor(input int unsigned candidate);
      longint unsigned p;
      int unsigned     k;
      bit              found;
      bit              done;
      found = 1'b0;
      done  = 1'b0;
      k     = 0;
      while (!done && k < found_count) begin
         p = primes_found[k];
         if (p >= 2) begin
            if (p * p > candidate) begin
               done = 1'b1;
            end else if (candidate % p == 0) begin
               found = 1'b1;
               done  = 1'b1;
            end
         end
         k++;
      end
      return found;
   endfunction

   // Extend the table as far as needed and answer request n
   function prime_answer_type predict_nth_prime(input logic [npg_pkg::INDEX_WIDTH-1:0] idx);
      prime_answer_type answer;
      int unsigned      n;
      longint unsigned  value_mask;
      value_mask = (64'd1 << npg_pkg::DEFAULT_PRIME_WIDTH) - 64'd1;
      n = 32'(idx);
      answer.prime_value = '0;
      answer.range_error = 1'b1;
      if (n == 0 || n > npg_pkg::DEFAULT_TABLE_DEPTH) begin
         return answer;
      end
      while (found_count < n && last_tried < value_mask) begin
         last_tried++;
         if (!has_divisor(last_tried) && found_count < npg_pkg::DEFAULT_TABLE_DEPTH) begin
            primes_found[found_count] = 32'(last_tried & value_mask);
            found_count++;
         end
      end
      if (found_count >= n) begin
         answer.prime_value = primes_found[n-1][npg_pkg::VALUE_WIDTH-1:0];
         answer.range_error = 1'b0;
      end
      return answer;
   endfunction

   function void note_request(input logic [npg_pkg::INDEX_WIDTH-1:0] idx);
      owed_answers = {owed_answers, predict_nth_prime(idx)};
   endfunction

   function int pending();
      return owed_answers.size();
   endfunction

   task report(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   // Compare one response with the oldest owed answer
   task check_response(input logic [npg_pkg::VALUE_WIDTH-1:0] value, input logic err);
      prime_answer_type want;
      if (owed_answers.size() == 0) begin
         report($sformatf("response value %0d error %b with no request owed", value, err));
      end else begin
         want = owed_answers.pop_front();
         if (value !== want.prime_value) begin
            report($sformatf("prime_value %0d, expected %0d", value, want.prime_value));
         end
         if (err !== want.range_error) begin
            report($sformatf("range_error %b, expected %b", err, want.range_error));
         end
      end
   endtask
endclass

module nth_prime_generator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Longest stretch without any transfer, well above the slowest table growth
   localparam int IDLE_LIMIT     = 10_000_000;
   localparam int LARGEST_INDEX  = 1024;
   localparam int RANDOM_ITEMS   = 80;
   localparam int LONG_HOLD      = 400;
   localparam int IDX_W          = npg_pkg::INDEX_WIDTH;

   logic clock = 1'b0;
   logic reset;

   npg_req_if req_chan ();
   npg_rsp_if rsp_chan ();

   nth_prime_generator_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   nth_prime_scoreboard_type ledger = new();

   int items_sent   = 0;
   int results_seen = 0;
   int idle_cycles  = 0;

   int directed_index [$] = '{1, 2, 3, 3, 1, 0, 8191, 4097, 6, 4, 5, 12, 7, 2, 0,
                              5000, 30, 25, 31, 8190, 4098};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Sender gap: none during one window of requests
   function int sender_gap();
      if (items_sent >= 40 && items_sent < 60) begin
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   // Receiver stall: one long hold, one window without stalls
   function int receiver_stall();
      if (results_seen == 30) begin
         return LONG_HOLD;
      end
      if (results_seen >= 70 && results_seen < 90) begin
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   // Mostly known or just-beyond indices, with errors and wider jumps mixed in
   function logic [npg_pkg::INDEX_WIDTH-1:0] pick_random_index(input int i);
      int unsigned known;
      int unsigned roll;
      int unsigned cap;
      int unsigned next;
      known = ledger.found_count;
      roll  = $urandom_range(0, 99);
      cap   = 40 + i * 9;
      if (cap > LARGEST_INDEX - 1) begin
         cap = LARGEST_INDEX - 1;
      end
      if (roll < 12) begin
         if ($urandom_range(0, 2) == 0) begin
            return '0;
         end
         return IDX_W'($urandom_range(npg_pkg::DEFAULT_TABLE_DEPTH + 1, 8191));
      end else if (roll < 40) begin
         return IDX_W'($urandom_range(1, known));
      end else if (roll < 75) begin
         next = known + $urandom_range(1, 8);
         if (next > LARGEST_INDEX - 1) begin
            next = $urandom_range(1, known);
         end
         return IDX_W'(next);
      end
      return IDX_W'($urandom_range(1, cap));
   endfunction

   // Offer one request after a gap, hold it until the transfer
   task automatic offer_request(input logic [npg_pkg::INDEX_WIDTH-1:0] idx, input int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.requested_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
      ledger.note_request(idx);
      items_sent++;
   endtask

   // Drop valid and wait until every owed response has come back
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   // Stimulus and end of run
   initial begin
      reset                    <= 1'b1;
      req_chan.valid           <= 1'b0;
      req_chan.requested_index <= '0;
      rsp_chan.ready           <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_index[k]) begin
         offer_request(IDX_W'(directed_index[k]), sender_gap());
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 60) begin
            drain_responses();
         end
         offer_request(pick_random_index(i), sender_gap());
      end

      // Largest request, then one already known and one just past it
      offer_request(IDX_W'(LARGEST_INDEX), sender_gap());
      offer_request(IDX_W'(LARGEST_INDEX - 1), sender_gap());
      offer_request(IDX_W'(LARGEST_INDEX + 1), sender_gap());

      drain_responses();
      repeat (50) @(posedge clock);
      if (ledger.pending() != 0) begin
         ledger.report($sformatf("%0d responses never arrived", ledger.pending()));
      end
      if (ledger.fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Accept responses with random stalls and check each one
   initial begin
      int stall;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = receiver_stall();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         ledger.check_response(rsp_chan.prime_value, rsp_chan.range_error);
         results_seen++;
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

endmodule
